@@ sv/ip_range_table_lookup_unit_defines.svh @@
// Assertion macros for the address range table.
`ifndef IP_RANGE_TABLE_LOOKUP_UNIT_DEFINES_SVH
`define IP_RANGE_TABLE_LOOKUP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define IPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ipr assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define IPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipr assertion failed");
`else
`define IPR_ASSERT(lbl, prop)
`define IPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/ipr_pkg.sv @@
package ipr_pkg;

  // Table geometry
  localparam int unsigned MAX_ENTRIES = 4096;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_APPENDED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [15:0] region_tag;
    logic [31:0] query_address;
  } ipr_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] match_start;
    logic [31:0] match_end;
    logic [15:0] match_tag;
  } ipr_out_t;

  // One stored range
  typedef struct packed {
    logic [31:0] rng_start;
    logic [31:0] rng_end;
    logic [15:0] rng_tag;
  } ipr_entry_t;

  // Requests from the command logic to the table
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    ipr_entry_t       wr_entry;
    logic             lk_start;
    logic [31:0]      lk_addr;
    logic [CNT_W-1:0] lk_count;
  } ipr_req_t;

  // Lookup completion from the table
  typedef struct packed {
    logic       done;
    logic       hit;
    ipr_entry_t entry;
  } ipr_rsp_t;

endpackage

@@ sv/ipr_table.sv @@
// Range memory with a binary search sequencer: one probe per cycle.
module ipr_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipr_pkg::ipr_req_t req_i,
  output ipr_pkg::ipr_rsp_t rsp_o
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_CHECK = 1'b1;

  ipr_pkg::ipr_entry_t mem [ipr_pkg::MAX_ENTRIES];
  ipr_pkg::ipr_entry_t rdata_q;

  logic                      state_q, state_d;
  logic [ipr_pkg::CNT_W-1:0] lo_q, lo_d;
  logic [ipr_pkg::CNT_W-1:0] hx_q, hx_d;
  logic [ipr_pkg::IDX_W-1:0] mid_q, mid_d;
  logic [31:0]               addr_q;

  logic                      hit_c, below_c, miss_c;
  logic [ipr_pkg::CNT_W-1:0] nlo_c, nhx_c;
  logic [ipr_pkg::CNT_W:0]   sum_start_c, sum_next_c;
  logic [ipr_pkg::IDX_W-1:0] mid_start_c, mid_next_c, rd_addr_c;

  // Compare the probed range against the query address
  assign hit_c   = (rdata_q.rng_start <= addr_q) && (rdata_q.rng_end >= addr_q);
  assign below_c = rdata_q.rng_end < addr_q;

  // Narrow the window: low bound inclusive, high bound exclusive
  assign nlo_c  = below_c ? (ipr_pkg::CNT_W'(mid_q) + 1'b1) : lo_q;
  assign nhx_c  = below_c ? hx_q : ipr_pkg::CNT_W'(mid_q);
  assign miss_c = nlo_c >= nhx_c;

  // Midpoints of the first and the next window
  assign sum_start_c = {1'b0, req_i.lk_count} - 1'b1;
  assign mid_start_c = sum_start_c[ipr_pkg::IDX_W:1];
  assign sum_next_c  = {1'b0, nlo_c} + {1'b0, nhx_c} - 1'b1;
  assign mid_next_c  = sum_next_c[ipr_pkg::IDX_W:1];

  assign rd_addr_c = (state_q == S_IDLE) ? mid_start_c : mid_next_c;

  // Advance the search
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hx_d    = hx_q;
    mid_d   = mid_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.lk_start) begin
          state_d = S_CHECK;
          lo_d    = '0;
          hx_d    = req_i.lk_count;
          mid_d   = mid_start_c;
        end
      end
      S_CHECK: begin
        if (hit_c || miss_c) begin
          state_d = S_IDLE;
        end else begin
          lo_d  = nlo_c;
          hx_d  = nhx_c;
          mid_d = mid_next_c;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the window and the query
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hx_q  <= hx_d;
    mid_q <= mid_d;
    if (req_i.lk_start && (state_q == S_IDLE)) begin
      addr_q <= req_i.lk_addr;
    end
  end

  // Write appended ranges; read the probe every cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_idx] <= req_i.wr_entry;
    end
    rdata_q <= mem[rd_addr_c];
  end

  assign rsp_o.done  = (state_q == S_CHECK) && (hit_c || miss_c);
  assign rsp_o.hit   = hit_c;
  assign rsp_o.entry = rdata_q;

endmodule

@@ sv/ip_range_table_lookup_unit.sv @@
// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       cmd_i    (ipr_in_t)
// result    out        done_o strobe, one cycle   result_o (ipr_out_t)
//
// Append, clear, unknown operations and a lookup of an empty table answer in
// the cycle after the transfer, and busy stays low.
// Any other lookup probes one entry per cycle, 1 to 13 probes for 4096
// entries, with busy high for those cycles; the result strobes in the cycle
// after the last probe, and no new command is taken until busy falls.
// Reset empties the table; stored ranges keep no reset value. No back-pressure.
`include "ip_range_table_lookup_unit_defines.svh"

module ip_range_table_lookup_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ipr_pkg::ipr_in_t  cmd_i,
  output logic              done_o,
  output ipr_pkg::ipr_out_t result_o
);

  logic [ipr_pkg::CNT_W-1:0] count_q, count_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  ipr_pkg::ipr_out_t         result_q, result_d;

  logic              acc_c, full_c, empty_c;
  ipr_pkg::ipr_req_t req;
  ipr_pkg::ipr_rsp_t rsp;

  logic simple_op_c, found_c, count_op_c;

  assign acc_c   = start && !busy_q;
  assign full_c  = count_q == ipr_pkg::CNT_W'(ipr_pkg::MAX_ENTRIES);
  assign empty_c = count_q == '0;

  // Drive table requests
  always_comb begin
    req.wr_en              = acc_c && (cmd_i.operation == ipr_pkg::OP_APPEND) && !full_c;
    req.wr_idx             = count_q[ipr_pkg::IDX_W-1:0];
    req.wr_entry.rng_start = cmd_i.range_start;
    req.wr_entry.rng_end   = cmd_i.range_end;
    req.wr_entry.rng_tag   = cmd_i.region_tag;
    req.lk_start           = acc_c && (cmd_i.operation == ipr_pkg::OP_LOOKUP) && !empty_c;
    req.lk_addr            = cmd_i.query_address;
    req.lk_count           = count_q;
  end

  ipr_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Decode the command and build the result
  always_comb begin
    count_d  = count_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    result_d = '0;
    result_d.status = ipr_pkg::ST_NOT_FOUND;
    if (busy_q) begin
      if (rsp.done) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (rsp.hit) begin
          result_d.status      = ipr_pkg::ST_FOUND;
          result_d.match_start = rsp.entry.rng_start;
          result_d.match_end   = rsp.entry.rng_end;
          result_d.match_tag   = rsp.entry.rng_tag;
        end
      end
    end else if (acc_c) begin
      unique case (cmd_i.operation)
        ipr_pkg::OP_APPEND: begin
          done_d = 1'b1;
          if (full_c) begin
            result_d.status = ipr_pkg::ST_FULL;
          end else begin
            result_d.status = ipr_pkg::ST_APPENDED;
            count_d         = count_q + 1'b1;
          end
        end
        ipr_pkg::OP_LOOKUP: begin
          // An empty table misses at once
          if (empty_c) begin
            done_d = 1'b1;
          end else begin
            busy_d = 1'b1;
          end
        end
        ipr_pkg::OP_CLEAR: begin
          done_d          = 1'b1;
          count_d         = '0;
          result_d.status = ipr_pkg::ST_CLEARED;
        end
        default: begin
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      result_q <= result_d;
    end
  end

  assign busy     = busy_q;
  assign done_o   = done_q;
  assign result_o = result_q;

  // Conditions watched by the checks below
  assign simple_op_c = acc_c && (cmd_i.operation != ipr_pkg::OP_LOOKUP);
  assign found_c     = done_o && (result_o.status == ipr_pkg::ST_FOUND);
  assign count_op_c  = acc_c && ((cmd_i.operation == ipr_pkg::OP_APPEND) ||
                                 (cmd_i.operation == ipr_pkg::OP_CLEAR));

  // A lookup ends only with a result strobe
  `IPR_ASSERT_NEXT(a_busy_ends_with_result, busy_q && rsp.done, done_o && !busy_q)
  // Operations other than a lookup answer in the next cycle
  `IPR_ASSERT_NEXT(a_simple_op_answers, simple_op_c, done_o)
  // A hit returns a range that holds at least one address
  `IPR_ASSERT(a_hit_is_ordered, !found_c || (result_o.match_start <= result_o.match_end))
  // The entry count changes only on a transfer of an append or a clear
  `IPR_ASSERT(a_count_moves_on_cmd, (count_q == $past(count_q)) || $past(count_op_c))

endmodule
